// ----- rtl/core/dfe_pkg.sv -----
// dfe_pkg: shared types, sizes and helper functions for the delimited frame extractor
// used by dfe_cell and delimited_frame_extractor; no dependencies
package dfe_pkg;

    localparam int MAX_DELIM_LEN = 4;
    localparam int LEN_W         = $clog2(MAX_DELIM_LEN + 1);
    localparam int CNT_W         = $clog2(MAX_DELIM_LEN + 2);
    localparam int PAT_BYTES     = 4;

    typedef logic [7:0]        t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        REG_START_PATTERN = 2'd0,
        REG_START_LENGTH  = 2'd1,
        REG_END_PATTERN   = 2'd2,
        REG_END_LENGTH    = 2'd3
    } t_reg_idx;

    // compare results of one window cell
    typedef struct packed {
        logic start_hit;
        logic stop_hit;
    } t_hit;

    // zero acts as one, anything above the maximum is clamped
    function automatic t_len eff_len(input logic [2:0] len);
        t_len r;
        if (len == 3'd0) begin
            r = t_len'(1);
        end else if (int'(len) > MAX_DELIM_LEN) begin
            r = t_len'(MAX_DELIM_LEN);
        end else begin
            r = t_len'(len);
        end
        return r;
    endfunction

    // pattern byte expected at a given age (0 = newest) for a delimiter of len bytes
    function automatic t_byte align_byte(input logic [31:0] pat, input t_len len,
                                         input int age);
        int k;
        t_byte r;
        k = int'(len) - 1 - age;
        if (k < 0 || k >= PAT_BYTES) begin
            r = 8'd0;
        end else begin
            r = pat[8*k +: 8];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/dfe_cell.sv -----
// dfe_cell: one byte stage of the delimiter window, compares the byte it is about to take
// depends on dfe_pkg
module dfe_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  dfe_pkg::t_byte  i_din,
    input  dfe_pkg::t_byte  i_start_pat,
    input  dfe_pkg::t_byte  i_stop_pat,
    output dfe_pkg::t_byte  o_q,
    output dfe_pkg::t_hit   o_hit
);

    dfe_pkg::t_byte r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_din;
        end
    end

    // hits describe the window as it stands after this shift
    assign o_hit.start_hit = (i_din == i_start_pat);
    assign o_hit.stop_hit  = (i_din == i_stop_pat);
    assign o_q             = r_q;

endmodule

// ----- rtl/core/delimited_frame_extractor.sv -----
// delimited_frame_extractor: finds start delimiter, forwards payload up to end delimiter
// a result is registered to the master side in the cycle after the byte transfer releasing it
// throughput: one byte per cycle unless the output stalls, with a combinational chain compare
// reset: synchronous active low, clears to hunting with empty window and default registers
// depends on dfe_pkg and dfe_cell
module delimited_frame_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] payload_byte
    output logic        o_m_axis_tlast,   // frame_last
    output logic [0:0]  o_m_axis_tuser    // [0] frame_empty
);

    localparam int N = dfe_pkg::MAX_DELIM_LEN;

    logic [31:0]    r_start_pat;
    logic [2:0]     r_start_len;
    logic [31:0]    r_stop_pat;
    logic [2:0]     r_stop_len;
    logic           r_in_payload;
    dfe_pkg::t_cnt  r_cnt;
    logic           r_out_valid;
    dfe_pkg::t_byte r_out_byte;
    logic           r_out_last;
    logic           r_out_empty;

    logic           n_in_payload;
    dfe_pkg::t_cnt  n_cnt;
    logic           n_load;
    dfe_pkg::t_byte n_out_byte;
    logic           n_out_last;
    logic           n_out_empty;

    logic           in_fire;
    logic           cfg_fire;
    dfe_pkg::t_len  sl;
    dfe_pkg::t_len  el;
    dfe_pkg::t_cnt  cnt_after;
    logic           start_match;
    logic           stop_match;
    dfe_pkg::t_byte rel_byte;

    dfe_pkg::t_byte cell_din [N];
    dfe_pkg::t_byte cell_q   [N];
    dfe_pkg::t_hit  cell_hit [N];

    assign o_cfg_ready     = 1'b1;
    assign cfg_fire        = i_cfg_valid;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign sl = dfe_pkg::eff_len(r_start_len);
    assign el = dfe_pkg::eff_len(r_stop_len);

    // window chain, cell k holds the byte of age k
    for (genvar k = 0; k < N; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_din[k] = i_s_axis_tdata;
        end else begin : g_link
            assign cell_din[k] = cell_q[k-1];
        end
        dfe_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (in_fire),
            .i_din       (cell_din[k]),
            .i_start_pat (dfe_pkg::align_byte(r_start_pat, sl, k)),
            .i_stop_pat  (dfe_pkg::align_byte(r_stop_pat, el, k)),
            .o_q         (cell_q[k]),
            .o_hit       (cell_hit[k])
        );
    end

    assign cnt_after = (int'(r_cnt) >= N + 1) ? r_cnt : r_cnt + dfe_pkg::t_cnt'(1);

    always_comb begin
        start_match = (cnt_after >= dfe_pkg::t_cnt'(sl));
        stop_match  = (cnt_after >= dfe_pkg::t_cnt'(el));
        rel_byte    = 8'd0;
        for (int k = 0; k < N; k++) begin
            if (k < int'(sl) && !cell_hit[k].start_hit) begin
                start_match = 1'b0;
            end
            if (k < int'(el) && !cell_hit[k].stop_hit) begin
                stop_match = 1'b0;
            end
            // byte of age el after the shift sits in cell el-1 now
            if (k == int'(el) - 1) begin
                rel_byte = cell_q[k];
            end
        end
    end

    always_comb begin
        n_in_payload = r_in_payload;
        n_cnt        = r_cnt;
        n_load       = 1'b0;
        n_out_byte   = rel_byte;
        n_out_last   = 1'b0;
        n_out_empty  = 1'b0;
        if (cfg_fire) begin
            n_in_payload = 1'b0;
            n_cnt        = '0;
        end else if (in_fire) begin
            if (!r_in_payload) begin
                if (start_match) begin
                    n_in_payload = 1'b1;
                    n_cnt        = '0;
                end else begin
                    n_cnt = cnt_after;
                end
            end else if (stop_match) begin
                n_load       = 1'b1;
                n_out_last   = 1'b1;
                n_in_payload = 1'b0;
                n_cnt        = '0;
                if (cnt_after <= dfe_pkg::t_cnt'(el)) begin
                    n_out_empty = 1'b1;
                    n_out_byte  = 8'd0;
                end
            end else if (cnt_after > dfe_pkg::t_cnt'(el)) begin
                // oldest byte can no longer be part of the end delimiter
                n_load = 1'b1;
                n_cnt  = dfe_pkg::t_cnt'(el);
            end else begin
                n_cnt = cnt_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pat  <= '0;
            r_start_len  <= 3'd1;
            r_stop_pat   <= '0;
            r_stop_len   <= 3'd1;
            r_in_payload <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (dfe_pkg::t_reg_idx'(i_cfg_index))
                    dfe_pkg::REG_START_PATTERN: r_start_pat <= i_cfg_data;
                    dfe_pkg::REG_START_LENGTH:  r_start_len <= i_cfg_data[2:0];
                    dfe_pkg::REG_END_PATTERN:   r_stop_pat  <= i_cfg_data;
                    dfe_pkg::REG_END_LENGTH:    r_stop_len  <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            r_in_payload <= n_in_payload;
            r_cnt        <= n_cnt;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_byte  <= n_out_byte;
            r_out_last  <= n_out_last;
            r_out_empty <= n_out_empty;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_byte;
    assign o_m_axis_tlast    = r_out_last;
    assign o_m_axis_tuser[0] = r_out_empty;

    // a pending result that is not taken must hold off new bytes
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while result stalled");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= N + 1)
        else $error("window count out of range");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tlast && o_m_axis_tdata == 8'd0))
        else $error("empty frame result malformed");

    a_cfg_drops_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_fire |=> (!r_in_payload && r_cnt == '0))
        else $error("config write did not return to hunting");

    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_in_payload) |-> !n_load)
        else $error("result produced while hunting");

endmodule

// ----- dv/tb_delimited_frame_extractor.sv -----
// tb_delimited_frame_extractor: self-checking bench for the start/end delimiter deframer
// directed table first, then random framed byte streams under several delimiter settings
// depends on dfe_pkg and delimited_frame_extractor
module tb_delimited_frame_extractor;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 100;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 85;
    localparam int MAX_PRINTS   = 30;

    typedef struct packed {
        dfe_pkg::t_byte payload;
        logic           last;
        logic           empty;
    } t_deframed;

    typedef struct {
        bit                class_dummy_unused_never;
    } t_unused_placeholder_never_declared;

    typedef struct {
        bit                is_cfg;
        dfe_pkg::t_reg_idx idx;
        logic [31:0]       value;
        bit                pinned;
        bit                has_res;
        t_deframed         res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [0:0]  o_m_axis_tuser;

    delimited_frame_extractor DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // deframer state as the bench sees it
    logic [31:0]    start_pat;
    logic [2:0]     start_len;
    logic [31:0]    end_pat;
    logic [2:0]     end_len;
    bit             in_frame;
    dfe_pkg::t_byte win [5];
    int             win_fill;

    t_deframed   payload_q [$];
    t_row        dir_rows [$];

    // pinned expectation for the byte currently offered
    bit          pin_use;
    bit          pin_has;
    t_deframed   pin_res;

    bit          quiet;
    bit          hold_req;
    int          err_cnt;
    int          n_bytes;
    int          n_results;
    int          n_frames;
    int          n_empty;
    int          n_cfg;

    function automatic int eff_delim_len(input logic [2:0] code);
        if (code == 3'd0) return 1;
        if (int'(code) > dfe_pkg::MAX_DELIM_LEN) return dfe_pkg::MAX_DELIM_LEN;
        return int'(code);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < 5; i++) win[i] = 8'd0;
        win_fill = 0;
    endfunction

    function automatic void drop_oldest_byte();
        if (win_fill == 0) return;
        for (int i = 1; i < 5; i++) win[i-1] = win[i];
        win[4] = 8'd0;
        win_fill--;
    endfunction

    function automatic void push_rx_byte(input dfe_pkg::t_byte b);
        if (win_fill >= 5) drop_oldest_byte();
        win[win_fill] = b;
        win_fill++;
    endfunction

    // newest len bytes of the window against the delimiter, first byte in low octet
    function automatic bit newest_match(input logic [31:0] pat, input int len);
        int base;
        if (win_fill < len) return 1'b0;
        base = win_fill - len;
        for (int k = 0; k < len; k++)
            if (win[base+k] != pat[8*k +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void apply_register(input dfe_pkg::t_reg_idx idx, input logic [31:0] v);
        case (idx)
            dfe_pkg::REG_START_PATTERN: start_pat = v;
            dfe_pkg::REG_START_LENGTH:  start_len = v[2:0];
            dfe_pkg::REG_END_PATTERN:   end_pat   = v;
            dfe_pkg::REG_END_LENGTH:    end_len   = v[2:0];
            default: ;
        endcase
        in_frame = 1'b0;
        clear_window();
    endfunction

    function automatic bit deframe_byte(input dfe_pkg::t_byte b, output t_deframed r);
        int sl;
        int el;
        r = '0;
        if (!in_frame) begin
            sl = eff_delim_len(start_len);
            while (win_fill >= sl) drop_oldest_byte();
            push_rx_byte(b);
            if (newest_match(start_pat, sl)) begin
                in_frame = 1'b1;
                clear_window();
            end
            return 1'b0;
        end
        el = eff_delim_len(end_len);
        while (win_fill > el) drop_oldest_byte();
        push_rx_byte(b);
        if (newest_match(end_pat, el)) begin
            r.last = 1'b1;
            if (win_fill > el) r.payload = win[win_fill-el-1];
            else               r.empty   = 1'b1;
            in_frame = 1'b0;
            clear_window();
            return 1'b1;
        end
        if (win_fill > el) begin
            r.payload = win[0];
            drop_oldest_byte();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report(input string what);
        if (err_cnt < MAX_PRINTS) $display("[%0t] error: %s", $realtime, what);
        err_cnt++;
    endtask

    // one process watches all three channels so the prediction order is fixed
    always @(posedge i_clk) begin
        t_deframed r;
        t_deframed e;
        bit        produced;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(dfe_pkg::t_reg_idx'(i_cfg_index), i_cfg_data);
                n_cfg++;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                produced = deframe_byte(i_s_axis_tdata, r);
                if (pin_use) begin
                    if (pin_has) payload_q.push_back(pin_res);
                end else if (produced) begin
                    payload_q.push_back(r);
                end
                n_bytes++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                n_results++;
                if (o_m_axis_tlast) n_frames++;
                if (o_m_axis_tuser[0]) n_empty++;
                if (payload_q.size() == 0) begin
                    report($sformatf("result %02h with nothing expected", o_m_axis_tdata));
                end else begin
                    e = payload_q.pop_front();
                    if (o_m_axis_tdata !== e.payload)
                        report($sformatf("payload_byte %02h, expected %02h",
                                         o_m_axis_tdata, e.payload));
                    if (o_m_axis_tlast !== e.last)
                        report($sformatf("frame_last %b, expected %b", o_m_axis_tlast, e.last));
                    if (o_m_axis_tuser[0] !== e.empty)
                        report($sformatf("frame_empty %b, expected %b",
                                         o_m_axis_tuser[0], e.empty));
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold on request, none once quiet
    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                i_m_axis_tready = 1'b1;
                @(negedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge i_clk);
            end
        end
    end

    // all byte tasks start and end right after a falling edge
    task automatic send_rx(input dfe_pkg::t_byte b, input bit pin, input bit has,
                           input t_deframed r);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        pin_use         = pin;
        pin_has         = has;
        pin_res         = r;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid = 1'b0;
        while (payload_q.size() != 0) @(negedge i_clk);
        // a byte that releases nothing yet may still be in flight
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input dfe_pkg::t_reg_idx idx, input logic [31:0] v);
        drain_results();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic row_cfg(input dfe_pkg::t_reg_idx idx, input logic [31:0] v);
        t_row w;
        w = '{is_cfg: 1'b1, idx: idx, value: v, pinned: 1'b0, has_res: 1'b0, res: '0};
        dir_rows.push_back(w);
    endtask

    task automatic row_rx(input dfe_pkg::t_byte b, input bit pinned, input bit has,
                          input dfe_pkg::t_byte pl, input bit last, input bit empty);
        t_row w;
        w = '{is_cfg: 1'b0, idx: dfe_pkg::REG_START_PATTERN, value: {24'd0, b},
              pinned: pinned, has_res: has, res: '{payload: pl, last: last, empty: empty}};
        dir_rows.push_back(w);
    endtask

    // half random, half a delimiter byte so partial matches show up
    function automatic dfe_pkg::t_byte pick_byte(input logic [31:0] sp, input logic [31:0] ep);
        case ($urandom_range(0, 3))
            0:       return sp[8*$urandom_range(0, 3) +: 8];
            1:       return ep[8*$urandom_range(0, 3) +: 8];
            default: return dfe_pkg::t_byte'($urandom);
        endcase
    endfunction

    initial begin
        logic [31:0]    sp;
        logic [31:0]    ep;
        logic [2:0]     sc;
        logic [2:0]     ec;
        logic [31:0]    rv [4];
        dfe_pkg::t_byte burst [$];
        t_row           w;
        int             sent;
        int             first;
        int             sl;
        int             el;
        int             plen;
        int             kind;
        bit             paused;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = dfe_pkg::REG_START_PATTERN;
        i_cfg_data      = 32'd0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        pin_use         = 1'b0;
        pin_has         = 1'b0;
        pin_res         = '0;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        err_cnt         = 0;
        n_bytes         = 0;
        n_results       = 0;
        n_frames        = 0;
        n_empty         = 0;
        n_cfg           = 0;
        start_pat       = 32'd0;
        start_len       = 3'd1;
        end_pat         = 32'd0;
        end_len         = 3'd1;
        in_frame        = 1'b0;
        clear_window();

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset delimiters are a single zero byte each
        row_rx(8'h00, 1, 0, 8'h00, 0, 0);
        row_rx(8'h00, 1, 1, 8'h00, 1, 1);
        row_rx(8'hFF, 1, 0, 8'h00, 0, 0);
        row_rx(8'h00, 1, 0, 8'h00, 0, 0);
        row_rx(8'hFF, 1, 0, 8'h00, 0, 0);
        row_rx(8'h00, 1, 1, 8'hFF, 1, 0);
        // lengths above the maximum and zero are clamped
        row_cfg(dfe_pkg::REG_START_PATTERN, 32'h4433_2211);
        row_cfg(dfe_pkg::REG_START_LENGTH,  32'd7);
        row_cfg(dfe_pkg::REG_END_PATTERN,   32'hFFFF_FFFF);
        row_cfg(dfe_pkg::REG_END_LENGTH,    32'd0);
        row_rx(8'h11, 0, 0, 8'h00, 0, 0);
        row_rx(8'h22, 0, 0, 8'h00, 0, 0);
        row_rx(8'h33, 0, 0, 8'h00, 0, 0);
        row_rx(8'h44, 0, 0, 8'h00, 0, 0);
        row_rx(8'h00, 0, 0, 8'h00, 0, 0);
        row_rx(8'h80, 0, 0, 8'h00, 0, 0);
        row_rx(8'hFF, 0, 0, 8'h00, 0, 0);
        // four byte end delimiter: empty frame, then a one byte frame
        row_cfg(dfe_pkg::REG_START_PATTERN, 32'h0000_00AA);
        row_cfg(dfe_pkg::REG_START_LENGTH,  32'd1);
        row_cfg(dfe_pkg::REG_END_PATTERN,   32'h0D0A_0D0A);
        row_cfg(dfe_pkg::REG_END_LENGTH,    32'd4);
        row_rx(8'hAA, 1, 0, 8'h00, 0, 0);
        row_rx(8'h0A, 0, 0, 8'h00, 0, 0);
        row_rx(8'h0D, 0, 0, 8'h00, 0, 0);
        row_rx(8'h0A, 0, 0, 8'h00, 0, 0);
        row_rx(8'h0D, 1, 1, 8'h00, 1, 1);
        row_rx(8'hAA, 1, 0, 8'h00, 0, 0);
        row_rx(8'h55, 0, 0, 8'h00, 0, 0);
        row_rx(8'h0A, 0, 0, 8'h00, 0, 0);
        row_rx(8'h0D, 0, 0, 8'h00, 0, 0);
        row_rx(8'h0A, 0, 0, 8'h00, 0, 0);
        row_rx(8'h0D, 1, 1, 8'h55, 1, 0);

        foreach (dir_rows[i]) begin
            w = dir_rows[i];
            if (w.is_cfg) write_reg(w.idx, w.value);
            else          send_rx(w.value[7:0], w.pinned, w.has_res, w.res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin sp = 32'd0;        ep = 32'hFFFF_FFFF; sc = 3'd1; ec = 3'd1; end
                1: begin sp = 32'hFFFF_FFFF; ep = 32'd0;        sc = 3'd4; ec = 3'd4; end
                default: begin
                    sp = $urandom;
                    ep = $urandom;
                    sc = 3'($urandom_range(0, 7));
                    ec = 3'($urandom_range(0, 7));
                end
            endcase
            rv[dfe_pkg::REG_START_PATTERN] = sp;
            rv[dfe_pkg::REG_START_LENGTH]  = {29'($urandom_range(0, 32'h1FFF_FFFF)), sc};
            rv[dfe_pkg::REG_END_PATTERN]   = ep;
            rv[dfe_pkg::REG_END_LENGTH]    = {29'($urandom_range(0, 32'h1FFF_FFFF)), ec};
            first = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++)
                write_reg(dfe_pkg::t_reg_idx'((first + k) % 4), rv[(first + k) % 4]);
            sl = eff_delim_len(sc);
            el = eff_delim_len(ec);
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            if (p == 2) hold_req = 1'b1;
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                if (p == 3 && !paused && sent >= 40) begin
                    drain_results();
                    paused = 1'b1;
                end
                burst.delete();
                repeat ($urandom_range(0, 3)) burst.push_back(pick_byte(sp, ep));
                for (int k = 0; k < sl; k++) burst.push_back(sp[8*k +: 8]);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(0, 8);
                repeat (plen) burst.push_back(pick_byte(sp, ep));
                kind = $urandom_range(0, 9);
                // an unterminated frame now and then: end delimiter cut short
                for (int k = 0; k < ((kind == 0) ? el - 1 : el); k++)
                    burst.push_back(ep[8*k +: 8]);
                foreach (burst[k]) begin
                    send_rx(burst[k], 1'b0, 1'b0, '0);
                    sent++;
                end
            end
        end

        i_s_axis_tvalid = 1'b0;
        for (int c = 0; c < 5000 && payload_q.size() != 0; c++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (payload_q.size() != 0)
            report($sformatf("%0d expected results never arrived", payload_q.size()));

        $display("covered %0d bytes, %0d register writes, %0d results in %0d frames (%0d empty)",
                 n_bytes, n_cfg, n_results, n_frames, n_empty);
        $display("delimiter lengths 0..7 written, stall bursts, one long output hold");
        if (err_cnt == 0) begin
            $display("delimited_frame_extractor: match");
        end else begin
            $display("delimited_frame_extractor: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", payload_q.size());
        $display("delimited_frame_extractor: mismatch");
        $finish;
    end

endmodule

// ----- delimited_frame_extractor.f -----
rtl/core/dfe_pkg.sv
rtl/core/dfe_cell.sv
rtl/core/delimited_frame_extractor.sv
dv/tb_delimited_frame_extractor.sv
